// File: src/ptwa_pkg.sv
package ptwa_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [7:0] MAX_AGE_RESET = 8'd3;

  localparam logic [1:0] OP_ANNOUNCE = 2'd0;
  localparam logic [1:0] OP_SWEEP    = 2'd1;
  localparam logic [1:0] OP_LIST     = 2'd2;

  localparam int          CFG_ADDR_W    = 3;
  localparam logic [2:0] REG_MAX_AGE   = 3'h0;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] port;
    logic [31:0] seen;
  } slot_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [31:0] now_seconds;
  } in_req_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] entry_address;
    logic [15:0] entry_port;
    logic [31:0] entry_seen;
    logic [3:0]  slot_index;
    logic        table_changed;
    logic        dropped;
    logic [4:0]  entry_count;
    logic        last;
  } out_res_t;

endpackage

// File: src/peer_table_with_aging_unit.sv
// An announce walks the slots from slot 0 until one matches the peer or the entry count is
// reached, then appends a new peer or drops it when full; a sweep walks all n entries.
// A list first sweeps, then reads each kept entry and emits it as one result; an unused
// operation only emits a result. Output stalls hold results back. The unit takes one
// request at a time; the next is accepted once the final result has been registered.
// Async reset clears the entry count and sets max age to 3; slots stay undefined until written.
module peer_table_with_aging_unit
  import ptwa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_res_t              out_res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANN_RD,
    S_ANN_CMP,
    S_SWP_RD,
    S_SWP_CHK,
    S_LST_RD,
    S_LST_OUT,
    S_EMIT
  } state_e;

  state_e           state_q, ret_q;
  in_req_t          req_q;
  logic [CNT_W-1:0] idx_q, kept_q, cnt_q;
  logic [31:0]      limit_q;
  logic             changed_q;
  logic [7:0]       age_q;
  out_res_t         pend_q, out_q;
  logic             out_valid_q;

  slot_t            mem_q [TABLE_ENTRIES];
  slot_t            rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_t            mem_wd;

  logic             in_acc, out_free, match, keep, full;
  logic [CNT_W-1:0] list_end;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_AGE) ? {24'd0, age_q} : 32'd0;

  assign match    = (rd_q.address == req_q.peer_address) && (rd_q.port == req_q.peer_port);
  assign keep     = (rd_q.seen >= limit_q);
  assign full     = (int'(cnt_q) >= TABLE_ENTRIES);
  assign list_end = (int'(cnt_q) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : cnt_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q[IDX_W-1:0];
    mem_wd = '{address: req_q.peer_address, port: req_q.peer_port, seen: req_q.now_seconds};
    unique case (state_q)
      S_ANN_RD: begin
        mem_we = (idx_q == cnt_q) && !full;
      end
      S_ANN_CMP: begin
        mem_we = match;
      end
      S_SWP_CHK: begin
        mem_we = keep;
        mem_wa = kept_q[IDX_W-1:0];
        mem_wd = rd_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= MAX_AGE_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_MAX_AGE)) begin
      age_q <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q     <= in_req_i;
            idx_q     <= '0;
            kept_q    <= '0;
            changed_q <= 1'b0;
            limit_q   <= (in_req_i.now_seconds > {24'd0, age_q}) ?
                         in_req_i.now_seconds - {24'd0, age_q} : 32'd0;
            ret_q     <= S_IDLE;
            pend_q    <= '{entry_count: 5'(cnt_q), last: 1'b1, default: '0};
            case (in_req_i.operation)
              OP_ANNOUNCE: state_q <= S_ANN_RD;
              OP_SWEEP:    state_q <= S_SWP_RD;
              OP_LIST:     state_q <= S_SWP_RD;
              default:     state_q <= S_EMIT;
            endcase
          end
        end
        S_ANN_RD: begin
          if (idx_q == cnt_q) begin
            if (!full) begin
              cnt_q                <= cnt_q + 1'b1;
              pend_q.entry_valid   <= 1'b1;
              pend_q.entry_address <= req_q.peer_address;
              pend_q.entry_port    <= req_q.peer_port;
              pend_q.entry_seen    <= req_q.now_seconds;
              pend_q.slot_index    <= 4'(idx_q);
              pend_q.table_changed <= 1'b1;
              pend_q.entry_count   <= 5'(cnt_q + 1'b1);
            end else begin
              pend_q.dropped <= 1'b1;
            end
            state_q <= S_EMIT;
          end else begin
            state_q <= S_ANN_CMP;
          end
        end
        S_ANN_CMP: begin
          if (match) begin
            pend_q.entry_valid   <= 1'b1;
            pend_q.entry_address <= rd_q.address;
            pend_q.entry_port    <= rd_q.port;
            pend_q.entry_seen    <= req_q.now_seconds;
            pend_q.slot_index    <= 4'(idx_q);
            state_q              <= S_EMIT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_ANN_RD;
          end
        end
        S_SWP_RD: begin
          if (idx_q == cnt_q) begin
            changed_q            <= (kept_q != cnt_q);
            cnt_q                <= kept_q;
            pend_q.table_changed <= (kept_q != cnt_q);
            pend_q.entry_count   <= 5'(kept_q);
            idx_q                <= '0;
            if ((req_q.operation == OP_LIST) && (kept_q != '0)) begin
              state_q <= S_LST_RD;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            state_q <= S_SWP_CHK;
          end
        end
        S_SWP_CHK: begin
          if (keep) begin
            kept_q <= kept_q + 1'b1;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= S_SWP_RD;
        end
        S_LST_RD: begin
          state_q <= S_LST_OUT;
        end
        S_LST_OUT: begin
          pend_q.entry_valid   <= 1'b1;
          pend_q.entry_address <= rd_q.address;
          pend_q.entry_port    <= rd_q.port;
          pend_q.entry_seen    <= rd_q.seen;
          pend_q.slot_index    <= 4'(idx_q);
          pend_q.table_changed <= changed_q;
          pend_q.entry_count   <= 5'(cnt_q);
          pend_q.last          <= (idx_q + 1'b1 == list_end);
          ret_q                <= (idx_q + 1'b1 == list_end) ? S_IDLE : S_LST_RD;
          idx_q                <= idx_q + 1'b1;
          state_q              <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= ret_q;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= TABLE_ENTRIES)
    else $error("entry count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while busy");

  a_slot_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.entry_valid |-> ({1'b0, out_res_o.slot_index} <
                                              out_res_o.entry_count))
    else $error("listed slot beyond entry count");

  a_drop_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.dropped |-> !out_res_o.entry_valid && out_res_o.last)
    else $error("dropped result carries an entry");
`endif

endmodule
